FILE: hw/rtl/sbas_pkg.sv
// sbas_pkg: shared types and codes for the signed BCD adder/subtractor.
// Holds sign, status and mode codes plus the control word passed along the digit chain.
// No dependencies.
`timescale 1ns / 1ps

package sbas_pkg;

  localparam int DIGITS_DEF = 8;
  localparam int MAG_W      = 32;
  localparam int DIG_W      = 4;

  typedef enum logic [1:0] {
    SGN_PLUS  = 2'd0,
    SGN_MINUS = 2'd1,
    SGN_ZERO  = 2'd2
  } sign_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    MODE_PASS_A,
    MODE_PASS_B,
    MODE_ADD,
    MODE_SUB
  } mode_t;

  // Per-beat control riding next to the digit vectors.
  typedef struct packed {
    mode_t mode;
    sign_t sgn_a;
    sign_t sgn_b;   // effective sign, already flipped for subtract
    logic  cy;      // decimal carry of a + b
    logic  bw_ab;   // borrow of a - b, i.e. a < b so far
    logic  bw_ba;   // borrow of b - a, i.e. b < a so far
    logic  eq;      // all digits so far equal
  } ctrl_t;

endpackage

FILE: hw/rtl/signed_bcd_add_sub.sv
// signed_bcd_add_sub: sign-magnitude packed BCD adder/subtractor, top level.
// Decode register, a chain of DIGITS sbas_cell digit cells, sbas_result. Depends on sbas_pkg.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+----------------------------
//   request  | op, sign_a, mag_a, sign_b, mag_b        | start & !busy takes a beat
//   result   | res_sign, res_mag, status               | done, one cycle, no stall
//
// One beat accepted per cycle; busy stays low.
// Registered stages: decode register, one cell per digit, result register.
// Each cell resolves one digit's carry and borrows, so the chain length sets the latency.
// rst (synchronous) clears all valid flags; beats in flight are dropped.
// The receiver cannot stall: done lasts exactly one cycle per beat.
`timescale 1ns / 1ps

module signed_bcd_add_sub #(
  parameter int DIGITS = sbas_pkg::DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       op,
  input  logic [1:0]                 sign_a,
  input  logic [sbas_pkg::MAG_W-1:0] mag_a,
  input  logic [1:0]                 sign_b,
  input  logic [sbas_pkg::MAG_W-1:0] mag_b,
  output logic                       done,
  output logic [1:0]                 res_sign,
  output logic [sbas_pkg::MAG_W-1:0] res_mag,
  output logic [1:0]                 status
);
  import sbas_pkg::*;

  localparam int MW = DIG_W * DIGITS;

  logic          vld  [DIGITS+1];
  ctrl_t         ctrl [DIGITS+1];
  logic [MW-1:0] va   [DIGITS+1];
  logic [MW-1:0] vb   [DIGITS+1];
  logic [MW-1:0] vsum [DIGITS+1];
  logic [MW-1:0] vdab [DIGITS+1];
  logic [MW-1:0] vdba [DIGITS+1];

  logic          accept;
  sign_t         sa, sb;
  ctrl_t         ctrl_next;
  logic [MW-1:0] ma, mb;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // digits above DIGITS are dropped; digits above the 32-bit field read as zero
  for (genvar j = 0; j < MW; j++) begin : g_in
    if (j < MAG_W) begin : g_bit
      assign ma[j] = mag_a[j];
      assign mb[j] = mag_b[j];
    end else begin : g_pad
      assign ma[j] = 1'b0;
      assign mb[j] = 1'b0;
    end
  end

  always_comb begin
    // code 3 reads as zero
    sa = sign_a[1] ? SGN_ZERO : sign_t'(sign_a);
    sb = sign_b[1] ? SGN_ZERO : sign_t'(sign_b);
    if (op && sb != SGN_ZERO) begin
      sb = (sb == SGN_PLUS) ? SGN_MINUS : SGN_PLUS;
    end
    ctrl_next.sgn_a = sa;
    ctrl_next.sgn_b = sb;
    ctrl_next.cy    = 1'b0;
    ctrl_next.bw_ab = 1'b0;
    ctrl_next.bw_ba = 1'b0;
    ctrl_next.eq    = 1'b1;
    priority if (sa == SGN_ZERO) begin
      ctrl_next.mode = MODE_PASS_B;
    end else if (sb == SGN_ZERO) begin
      ctrl_next.mode = MODE_PASS_A;
    end else if (sa == sb) begin
      ctrl_next.mode = MODE_ADD;
    end else begin
      ctrl_next.mode = MODE_SUB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
    ctrl[0] <= ctrl_next;
    va[0]   <= ma;
    vb[0]   <= mb;
    vsum[0] <= '0;
    vdab[0] <= '0;
    vdba[0] <= '0;
  end

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    sbas_cell #(
      .DIGITS (DIGITS),
      .IDX    (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (vld[i]),
      .in_ctrl  (ctrl[i]),
      .in_a     (va[i]),
      .in_b     (vb[i]),
      .in_sum   (vsum[i]),
      .in_dab   (vdab[i]),
      .in_dba   (vdba[i]),
      .out_vld  (vld[i+1]),
      .out_ctrl (ctrl[i+1]),
      .out_a    (va[i+1]),
      .out_b    (vb[i+1]),
      .out_sum  (vsum[i+1]),
      .out_dab  (vdab[i+1]),
      .out_dba  (vdba[i+1])
    );
  end

  sbas_result #(
    .DIGITS (DIGITS)
  ) u_result (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (vld[DIGITS]),
    .in_ctrl  (ctrl[DIGITS]),
    .in_a     (va[DIGITS]),
    .in_b     (vb[DIGITS]),
    .in_sum   (vsum[DIGITS]),
    .in_dab   (vdab[DIGITS]),
    .in_dba   (vdba[DIGITS]),
    .done     (done),
    .res_sign (res_sign),
    .res_mag  (res_mag),
    .status   (status)
  );

  // every result beat traces back to an accepted request through the decode register, the cells and the result register
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, DIGITS + 2))
    else $error("signed_bcd_add_sub: result beat without matching request");

endmodule

FILE: hw/rtl/sbas_cell.sv
// sbas_cell: one digit cell of the chain; handles digit IDX of a beat and registers it.
// Computes a+b, a-b and b-a digits with carry/borrow in. Depends on sbas_pkg.
`timescale 1ns / 1ps

module sbas_cell #(
  parameter int DIGITS = sbas_pkg::DIGITS_DEF,
  parameter int IDX    = 0,
  localparam int MW    = sbas_pkg::DIG_W * DIGITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  sbas_pkg::ctrl_t in_ctrl,
  input  logic [MW-1:0]   in_a,
  input  logic [MW-1:0]   in_b,
  input  logic [MW-1:0]   in_sum,
  input  logic [MW-1:0]   in_dab,
  input  logic [MW-1:0]   in_dba,
  output logic            out_vld,
  output sbas_pkg::ctrl_t out_ctrl,
  output logic [MW-1:0]   out_a,
  output logic [MW-1:0]   out_b,
  output logic [MW-1:0]   out_sum,
  output logic [MW-1:0]   out_dab,
  output logic [MW-1:0]   out_dba
);
  import sbas_pkg::*;

  localparam int LSB = DIG_W * IDX;

  logic [3:0]    da, db;
  logic [4:0]    s5, t_ab, t_ba;
  logic [3:0]    sd, dab_d, dba_d;
  logic          co, lt_ab, lt_ba;
  ctrl_t         ctrl_next;
  logic [MW-1:0] sum_next, dab_next, dba_next;

  always_comb begin
    da = in_a[LSB +: DIG_W];
    db = in_b[LSB +: DIG_W];

    // digits may exceed 9: fold once by ten, keep the low nibble
    s5 = {1'b0, da} + {1'b0, db} + {4'd0, in_ctrl.cy};
    co = (s5 > 5'd9);
    sd = co ? 4'(s5 - 5'd10) : s5[3:0];

    t_ab  = {1'b0, da} - {1'b0, db} - {4'd0, in_ctrl.bw_ab};
    t_ba  = {1'b0, db} - {1'b0, da} - {4'd0, in_ctrl.bw_ba};
    lt_ab = (da < db) || ((da == db) && in_ctrl.bw_ab);
    lt_ba = (db < da) || ((da == db) && in_ctrl.bw_ba);
    dab_d = lt_ab ? 4'(t_ab[3:0] + 4'd10) : t_ab[3:0];
    dba_d = lt_ba ? 4'(t_ba[3:0] + 4'd10) : t_ba[3:0];

    ctrl_next       = in_ctrl;
    ctrl_next.cy    = co;
    ctrl_next.bw_ab = lt_ab;
    ctrl_next.bw_ba = lt_ba;
    ctrl_next.eq    = in_ctrl.eq && (da == db);

    sum_next = in_sum;
    dab_next = in_dab;
    dba_next = in_dba;
    sum_next[LSB +: DIG_W] = sd;
    dab_next[LSB +: DIG_W] = dab_d;
    dba_next[LSB +: DIG_W] = dba_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
    out_ctrl <= ctrl_next;
    out_a    <= in_a;
    out_b    <= in_b;
    out_sum  <= sum_next;
    out_dab  <= dab_next;
    out_dba  <= dba_next;
  end

  // a<b and b<a cannot both hold over the same digits
  a_bw_excl: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(out_ctrl.bw_ab && out_ctrl.bw_ba))
    else $error("sbas_cell: both borrows set");

  a_eq_noborrow: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_ctrl.mode == MODE_SUB && out_ctrl.eq) |->
      (!out_ctrl.bw_ab && !out_ctrl.bw_ba))
    else $error("sbas_cell: equal digits with borrow");

endmodule

FILE: hw/rtl/sbas_result.sv
// sbas_result: end of the chain; picks a passed operand, the sum or a difference, sets sign and status.
// Registers the result beat and its strobe. Depends on sbas_pkg.
`timescale 1ns / 1ps

module sbas_result #(
  parameter int DIGITS = sbas_pkg::DIGITS_DEF,
  localparam int MW    = sbas_pkg::DIG_W * DIGITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_vld,
  input  sbas_pkg::ctrl_t            in_ctrl,
  input  logic [MW-1:0]              in_a,
  input  logic [MW-1:0]              in_b,
  input  logic [MW-1:0]              in_sum,
  input  logic [MW-1:0]              in_dab,
  input  logic [MW-1:0]              in_dba,
  output logic                       done,
  output logic [1:0]                 res_sign,
  output logic [sbas_pkg::MAG_W-1:0] res_mag,
  output logic [1:0]                 status
);
  import sbas_pkg::*;

  sign_t            rs;
  logic [MW-1:0]    rm;
  logic [1:0]       st;
  logic [MAG_W-1:0] rm_out;

  always_comb begin
    rs = SGN_ZERO;
    rm = '0;
    st = ST_OK;
    unique case (in_ctrl.mode)
      MODE_PASS_B: begin
        rs = in_ctrl.sgn_b;
        rm = in_b;
      end
      MODE_PASS_A: begin
        rs = in_ctrl.sgn_a;
        rm = in_a;
      end
      MODE_ADD: begin
        rs = in_ctrl.sgn_a;
        rm = in_sum;
        if (in_ctrl.cy) begin
          st = ST_OVF;
        end
      end
      MODE_SUB: begin
        if (in_ctrl.eq) begin
          // equal magnitudes: zero for a single digit, else out of range
          if (DIGITS > 1) begin
            st = ST_RANGE;
          end
        end else begin
          rs = in_ctrl.bw_ab ? in_ctrl.sgn_b : in_ctrl.sgn_a;
          rm = in_ctrl.bw_ab ? in_dba : in_dab;
          if ((DIGITS > 1) && (rm[MW-1 -: DIG_W] == '0)) begin
            st = ST_RANGE;
          end
        end
      end
      default: begin
        rs = SGN_ZERO;
      end
    endcase
    if (st != ST_OK) begin
      rs = SGN_ZERO;
      rm = '0;
    end
  end

  // fit the internal magnitude to the 32-bit result field
  for (genvar j = 0; j < MAG_W; j++) begin : g_out
    if (j < MW) begin : g_bit
      assign rm_out[j] = rm[j];
    end else begin : g_pad
      assign rm_out[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
    res_sign <= rs;
    res_mag  <= rm_out;
    status   <= st;
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (res_sign == SGN_ZERO && res_mag == '0))
    else $error("sbas_result: error beat with nonzero result");

  a_ovf_add: assert property (@(posedge clk) disable iff (rst)
    (in_vld && in_ctrl.mode != MODE_ADD) |=> (status != ST_OVF))
    else $error("sbas_result: overflow outside add");

endmodule
